// ----- design/lpe_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and the weight table of the line position estimator.
package lpe_pkg;

   // Array shape
   localparam int CHANNELS      = 8;
   localparam int SAMPLE_BITS   = 10;
   localparam int CHAN_W        = $clog2(CHANNELS);
   localparam int CAL_REGS      = (CHANNELS + 1) / 2;
   localparam int CAL_IDX_W     = $clog2(CAL_REGS);
   localparam int CAL_W         = 4 * SAMPLE_BITS;
   localparam int CONTRAST_W    = 10;

   // Scaling and centroid constants
   localparam int NORM_SCALE_SH    = 10;
   localparam int WEIGHT_STEP      = 1000;
   localparam int SPAN             = WEIGHT_STEP * (CHANNELS - 1);
   localparam int CENTER           = SPAN / 2;
   localparam int POS_LIMIT        = 3500;
   localparam int SPREAD_START_MIN = 7000;

   // Datapath widths
   localparam int POS_W      = 13;
   localparam int NORM_MAG_W = SAMPLE_BITS + NORM_SCALE_SH;
   localparam int NORM_W     = NORM_MAG_W + 1;
   localparam int WEIGHT_W   = $clog2(CENTER + 1) + 1;
   localparam int PROD_W     = NORM_W + WEIGHT_W;
   localparam int ACC_W      = PROD_W + CHAN_W;
   localparam int SUM_W      = NORM_W + CHAN_W;
   localparam int DEN_W      = SUM_W;
   localparam int CNT_W      = $clog2(ACC_W + 1);
   localparam int SPREAD_W   = NORM_W + 1;

   // Saturated off-line and empty-sum positions
   localparam int POS_HIGH = (SPAN - CENTER > POS_LIMIT) ? POS_LIMIT : SPAN - CENTER;
   localparam int POS_LOW  = (CENTER > POS_LIMIT) ? -POS_LIMIT : -CENTER;

   // Register file
   localparam int CSR_DATA_W = 64;
   localparam int PADDR_W    = $clog2(8 * (CAL_REGS + 1));
   localparam int REG_IDX_W  = PADDR_W - 3;
   localparam logic [REG_IDX_W-1:0] REG_CAL_PAIR_01    = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_CAL_PAIR_67    = REG_IDX_W'(CAL_REGS - 1);
   localparam logic [REG_IDX_W-1:0] REG_CONTRAST_LEVEL = REG_IDX_W'(CAL_REGS);

   // Limits after reset: low 0, high full scale on both channels
   localparam logic [CAL_W-1:0] CAL_RESET = {{SAMPLE_BITS{1'b1}}, {SAMPLE_BITS{1'b0}},
                                             {SAMPLE_BITS{1'b1}}, {SAMPLE_BITS{1'b0}}};

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_0;
      logic [SAMPLE_BITS-1:0] sample_1;
      logic [SAMPLE_BITS-1:0] sample_2;
      logic [SAMPLE_BITS-1:0] sample_3;
      logic [SAMPLE_BITS-1:0] sample_4;
      logic [SAMPLE_BITS-1:0] sample_5;
      logic [SAMPLE_BITS-1:0] sample_6;
      logic [SAMPLE_BITS-1:0] sample_7;
   } req_word_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic                    off_line;
      logic [CHAN_W-1:0]       last_channel;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_ACC,
      ST_CHECK,
      ST_POS,
      ST_FINISH
   } lpe_state_type;

   // Channel weight relative to the array center
   function automatic logic signed [WEIGHT_W-1:0] chan_weight(input logic [CHAN_W-1:0] ch);
      return WEIGHT_W'(WEIGHT_STEP * int'(ch) - CENTER);
   endfunction

endpackage

// ----- design/line_position_estimator_unit.sv -----
`timescale 1ns / 1ps
// Line position estimator: per-channel normalization and centroid on one shared divider.
// A channel with degenerate limits skips its normalization division, and an off-line scan
//   skips the centroid division.
// One scan at a time: the next word is taken only in idle. The shared divider makes one bit per cycle
//   (20 steps per channel normalization, 37 steps for the centroid quotient).
// The next word is taken while a finished result still waits in the output register.
// Reset (synchronous, active high): idle, no result pending, limits low 0 / high full
//   scale, contrast 0, strongest channel 0.
module line_position_estimator_unit
   import lpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Control state
   lpe_state_type state_ff, state_in;
   logic [CAL_W-1:0]      cal_ff [CAL_REGS];
   logic [CONTRAST_W-1:0] contrast_ff;
   logic [CHAN_W-1:0]     strongest_ff, strongest_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [SAMPLE_BITS-1:0]    samp_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0]    samp_in [CHANNELS];
   logic [CHAN_W-1:0]         chan_ff, chan_in;
   logic                      final_ff, final_in;
   logic                      neg_ff, neg_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [ACC_W-1:0]          quo_ff, quo_in;
   logic signed [ACC_W-1:0]   wsum_ff, wsum_in;
   logic signed [SUM_W-1:0]   nsum_ff, nsum_in;
   logic signed [NORM_W-1:0]  max_ff, max_in;
   logic signed [NORM_W-1:0]  min_ff, min_in;
   logic signed [NORM_W-1:0]  best_ff, best_in;
   logic [CHAN_W-1:0]         best_idx_ff, best_idx_in;
   logic                      best_hit_ff, best_hit_in;
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic                      off_ff, off_in;
   rsp_word_type              rsp_data_ff, rsp_data_in;

   // Sequencer controls
   logic do_accept, do_load, do_step, do_acc, do_check, do_pos, do_finish;

   // Datapath wires
   logic [CAL_W-1:0]            cur_cal;
   logic [SAMPLE_BITS-1:0]      cur_lo, cur_hi, cur_s, off_mag;
   logic signed [SAMPLE_BITS:0] off_raw, span_raw;
   logic                        degenerate;
   logic [DEN_W:0]              rem_sh;
   logic [DEN_W+1:0]            trial;
   logic                        fits;
   logic signed [NORM_W-1:0]    n_mag, n_cur;
   logic signed [PROD_W-1:0]    prod;
   logic signed [SPREAD_W-1:0]  spread, half_contrast;
   logic                        offline_now;
   logic [POS_W-1:0]            pos_mag;
   logic [REG_IDX_W-1:0]        csr_idx;
   logic                        csr_write;

   // Register file access
   assign pready    = 1'b1;
   assign csr_idx   = paddr[PADDR_W-1:3];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (csr_idx) inside
         [REG_CAL_PAIR_01:REG_CAL_PAIR_67]: begin
            prdata = CSR_DATA_W'(cal_ff[csr_idx[CAL_IDX_W-1:0]]);
         end
         REG_CONTRAST_LEVEL: begin
            prdata = CSR_DATA_W'(contrast_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = degenerate ? ST_ACC : ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(1)) state_in = final_ff ? ST_POS : ST_ACC;
         end
         ST_ACC: begin
            state_in = (chan_ff == CHAN_W'(CHANNELS - 1)) ? ST_CHECK : ST_LOAD;
         end
         ST_CHECK: begin
            state_in = (offline_now || nsum_ff <= 0) ? ST_FINISH : ST_DIV;
         end
         ST_POS: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      do_load   = 1'b0;
      do_step   = 1'b0;
      do_acc    = 1'b0;
      do_check  = 1'b0;
      do_pos    = 1'b0;
      do_finish = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_LOAD:   do_load   = 1'b1;
         ST_DIV:    do_step   = 1'b1;
         ST_ACC:    do_acc    = 1'b1;
         ST_CHECK:  do_check  = 1'b1;
         ST_POS:    do_pos    = 1'b1;
         ST_FINISH: do_finish = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign do_accept = req_valid && req_ready;

   // Limits and sample of the current channel
   always_comb begin
      cur_cal  = cal_ff[chan_ff[CHAN_W-1:1]];
      cur_lo   = chan_ff[0] ? cur_cal[3*SAMPLE_BITS-1:2*SAMPLE_BITS] : cur_cal[SAMPLE_BITS-1:0];
      cur_hi   = chan_ff[0] ? cur_cal[4*SAMPLE_BITS-1:3*SAMPLE_BITS]
                            : cur_cal[2*SAMPLE_BITS-1:SAMPLE_BITS];
      cur_s    = samp_ff[chan_ff];
      off_raw  = $signed({1'b0, cur_s}) - $signed({1'b0, cur_lo});
      span_raw = $signed({1'b0, cur_hi}) - $signed({1'b0, cur_lo});
      degenerate = span_raw[SAMPLE_BITS] || (span_raw == '0);
      off_mag  = off_raw[SAMPLE_BITS] ? SAMPLE_BITS'(-off_raw) : off_raw[SAMPLE_BITS-1:0];
   end

   // Shared divider: one restoring step per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[ACC_W-1]};
      trial  = {1'b0, rem_sh} - {2'b00, den_ff};
      fits   = !trial[DEN_W+1];
   end

   // Normalized value, weighted term, spread test, saturated quotient
   always_comb begin
      n_mag   = $signed({1'b0, quo_ff[NORM_MAG_W-1:0]});
      n_cur   = neg_ff ? -n_mag : n_mag;
      prod    = n_cur * chan_weight(chan_ff);
      spread  = SPREAD_W'(max_ff) - SPREAD_W'(min_ff);
      half_contrast = $signed(SPREAD_W'(contrast_ff >> 1));
      offline_now   = spread < half_contrast;
      pos_mag = (quo_ff > ACC_W'(POS_LIMIT)) ? POS_W'(POS_LIMIT) : quo_ff[POS_W-1:0];
   end

   // Datapath next values
   always_comb begin
      samp_in     = samp_ff;
      chan_in     = chan_ff;
      final_in    = final_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      quo_in      = quo_ff;
      wsum_in     = wsum_ff;
      nsum_in     = nsum_ff;
      max_in      = max_ff;
      min_in      = min_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      best_hit_in = best_hit_ff;
      pos_in      = pos_ff;
      off_in      = off_ff;
      strongest_in = strongest_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Take a new word and clear the accumulators
      if (do_accept) begin
         samp_in[0]  = req_data.sample_0;
         samp_in[1]  = req_data.sample_1;
         samp_in[2]  = req_data.sample_2;
         samp_in[3]  = req_data.sample_3;
         samp_in[4]  = req_data.sample_4;
         samp_in[5]  = req_data.sample_5;
         samp_in[6]  = req_data.sample_6;
         samp_in[7]  = req_data.sample_7;
         chan_in     = '0;
         final_in    = 1'b0;
         wsum_in     = '0;
         nsum_in     = '0;
         max_in      = '0;
         min_in      = NORM_W'(SPREAD_START_MIN);
         best_in     = '0;
         best_idx_in = '0;
         best_hit_in = 1'b0;
      end

      // Set up the normalization of one channel
      if (do_load) begin
         rem_in = '0;
         cnt_in = CNT_W'(NORM_MAG_W);
         den_in = DEN_W'(span_raw[SAMPLE_BITS-1:0]);
         if (degenerate) begin
            quo_in = '0;
            neg_in = 1'b0;
         end else begin
            quo_in = {off_mag, {(ACC_W - SAMPLE_BITS){1'b0}}};
            neg_in = off_raw[SAMPLE_BITS];
         end
      end

      // Advance the divider
      if (do_step) begin
         rem_in = fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_in = {quo_ff[ACC_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
      end

      // Fold the normalized value into sums, spread and strongest candidate
      if (do_acc) begin
         wsum_in = wsum_ff + ACC_W'(prod);
         nsum_in = nsum_ff + SUM_W'(n_cur);
         if (n_cur > max_ff) max_in = n_cur;
         if (n_cur < min_ff) min_in = n_cur;
         if (n_cur > best_ff) begin
            best_in     = n_cur;
            best_idx_in = chan_ff;
            best_hit_in = 1'b1;
         end
         chan_in = chan_ff + CHAN_W'(1);
      end

      // Decide off-line, update strongest channel, start the centroid division
      if (do_check) begin
         off_in = offline_now;
         if (offline_now) begin
            pos_in = (strongest_ff == CHAN_W'(CHANNELS - 1)) ? POS_W'(POS_HIGH)
                                                           : POS_W'(POS_LOW);
         end else begin
            if (best_hit_ff) strongest_in = best_idx_ff;
            pos_in   = POS_W'(POS_LOW);
            rem_in   = '0;
            cnt_in   = CNT_W'(ACC_W);
            den_in   = nsum_ff[DEN_W-1:0];
            neg_in   = wsum_ff[ACC_W-1];
            quo_in   = wsum_ff[ACC_W-1] ? ACC_W'(-wsum_ff) : wsum_ff;
            final_in = 1'b1;
         end
      end

      // Saturate and sign the centroid
      if (do_pos) begin
         pos_in = neg_ff ? -$signed(pos_mag) : $signed(pos_mag);
      end

      // Hand the result word to the output register
      if (do_finish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.position     = pos_ff;
         rsp_data_in.off_line     = off_ff;
         rsp_data_in.last_channel = strongest_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         strongest_ff <= '0;
         contrast_ff  <= '0;
         for (int i = 0; i < CAL_REGS; i++) begin
            cal_ff[i] <= CAL_RESET;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         strongest_ff <= strongest_in;
         if (csr_write) begin
            case (csr_idx) inside
               [REG_CAL_PAIR_01:REG_CAL_PAIR_67]: begin
                  cal_ff[csr_idx[CAL_IDX_W-1:0]] <= pwdata[CAL_W-1:0];
               end
               REG_CONTRAST_LEVEL: begin
                  contrast_ff <= pwdata[CONTRAST_W-1:0];
               end
               default: begin
                  contrast_ff <= contrast_ff;
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      samp_ff     <= samp_in;
      chan_ff     <= chan_in;
      final_ff    <= final_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      wsum_ff     <= wsum_in;
      nsum_ff     <= nsum_in;
      max_ff      <= max_in;
      min_ff      <= min_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      best_hit_ff <= best_hit_in;
      pos_ff      <= pos_in;
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // Divider remainder stays below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   // A normalization quotient fits its magnitude width
   a_norm_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (quo_ff[ACC_W-1:NORM_MAG_W] == '0))
      else $error("normalized value overflows");

   // A pending result lies within the saturation limits
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.position <= POS_W'(POS_LIMIT) &&
                     rsp_data.position >= -POS_W'(POS_LIMIT)))
      else $error("position outside saturation range");

   // An accepted word starts at the first channel
   a_start_chan0: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_LOAD && chan_ff == '0 && !final_ff))
      else $error("scan did not start at channel zero");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the line position estimator: scoreboard against an in-bench model.
module tb_top
   import lpe_pkg::*;
();

   typedef enum int {
      LIM_WIDE,
      LIM_RAW,
      LIM_NARROW,
      LIM_ALL_ONES,
      LIM_ALL_ZEROS,
      LIM_MIXED
   } limit_style_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [PADDR_W-1:0]    paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Mirror of the calibration registers and the channel tracker
   logic [CAL_W-1:0]      cal_limits [CAL_REGS];
   logic [CONTRAST_W-1:0] contrast_level = '0;
   logic [CHAN_W-1:0]     strongest_seen = '0;

   req_word_type pending_scans [$];
   rsp_word_type predicted_positions [$];
   rsp_word_type want;

   int gap_left         = 0;
   int scans_accepted   = 0;
   int results_checked  = 0;
   int off_line_seen    = 0;
   int saturated_seen   = 0;
   int settings_written = 0;
   int failures         = 0;

   line_position_estimator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 clock = ~clock;

   initial begin
      for (int k = 0; k < CAL_REGS; k++) cal_limits[k] = CAL_RESET;
   end

   // Keep both sides busy through the middle of the run
   function automatic bit quiet_window();
      return scans_accepted >= 500 && scans_accepted < 650;
   endfunction

   function automatic bit take_pause();
      return !quiet_window() && ($urandom_range(99) < 18);
   endfunction

   // Normalize every channel, form the centroid and track the strongest channel
   function automatic rsp_word_type estimate_position(input req_word_type scan);
      longint norm [CHANNELS];
      longint lo_lim, hi_lim, raw, total, sum, top, bottom, half, best, pos;
      int     base;
      logic   off;
      rsp_word_type res;
      total  = 0;
      sum    = 0;
      top    = 0;
      bottom = SPREAD_START_MIN;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         base   = (ch % 2) * 2 * SAMPLE_BITS;
         lo_lim = cal_limits[ch / 2][base +: SAMPLE_BITS];
         hi_lim = cal_limits[ch / 2][base + SAMPLE_BITS +: SAMPLE_BITS];
         raw    = scan[(CHANNELS - 1 - ch) * SAMPLE_BITS +: SAMPLE_BITS];
         if (hi_lim <= lo_lim)
            norm[ch] = 0;
         else
            norm[ch] = ((raw - lo_lim) * (longint'(1) << NORM_SCALE_SH)) / (hi_lim - lo_lim);
         total += norm[ch] * WEIGHT_STEP * ch;
         sum   += norm[ch];
         if (norm[ch] > top) top = norm[ch];
         if (norm[ch] < bottom) bottom = norm[ch];
      end
      half = contrast_level >> 1;
      off  = (top - bottom) < half;
      if (!off) begin
         // lowest channel with the strictly greatest positive value wins
         best = 0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            if (norm[ch] > best) begin
               best           = norm[ch];
               strongest_seen = CHAN_W'(ch);
            end
         end
         pos = (sum > 0) ? (total - CENTER * sum) / sum : -CENTER;
      end else begin
         pos = (strongest_seen == CHANNELS - 1) ? SPAN - CENTER : -CENTER;
      end
      if (pos > POS_LIMIT) pos = POS_LIMIT;
      if (pos < -POS_LIMIT) pos = -POS_LIMIT;
      res.position     = pos[POS_W-1:0];
      res.off_line     = off;
      res.last_channel = strongest_seen;
      return res;
   endfunction

   // Flat scan at base with one channel raised to peak (peak_ch < 0: none)
   function automatic req_word_type make_scan(input int base, input int peak_ch, input int peak);
      req_word_type scan;
      for (int ch = 0; ch < CHANNELS; ch++)
         scan[(CHANNELS - 1 - ch) * SAMPLE_BITS +: SAMPLE_BITS] =
            SAMPLE_BITS'((ch == peak_ch) ? peak : base);
      return scan;
   endfunction

   // Line-shaped scans (the largest share), plus noise, near-flat scans and rail values
   function automatic req_word_type random_scan();
      req_word_type scan;
      int pick, peak_ch, level, val;
      bit spread_peak;
      pick        = $urandom_range(99);
      peak_ch     = $urandom_range(CHANNELS - 1);
      spread_peak = 1'($urandom_range(1));
      level       = $urandom_range(1008, 15);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (pick < 25) begin
            val = $urandom;
         end else if (pick < 70) begin
            if (ch == peak_ch)
               val = $urandom_range(1023, 600);
            else if (spread_peak && (ch == peak_ch + 1 || ch == peak_ch - 1))
               val = $urandom_range(700, 300);
            else
               val = $urandom_range(200);
         end else if (pick < 85) begin
            val = level + $urandom_range(30) - 15;
         end else begin
            val = $urandom_range(1) ? 1023 : 0;
         end
         scan[(CHANNELS - 1 - ch) * SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(val);
      end
      return scan;
   endfunction

   // Low/high limits for both channels of one register
   function automatic logic [CAL_W-1:0] limit_word(input limit_style_type style);
      logic [CAL_W-1:0] w;
      int lo;
      w = '0;
      // a mixed phase picks one of the plain styles per register
      if (style == LIM_MIXED) style = limit_style_type'($urandom_range(LIM_ALL_ZEROS));
      case (style)
         LIM_WIDE: begin
            for (int c = 0; c < 2; c++) begin
               w[c * 20 +: 10]      = 10'($urandom_range(300));
               w[c * 20 + 10 +: 10] = 10'($urandom_range(1023, 700));
            end
         end
         LIM_RAW: begin
            w = CAL_W'({$urandom, $urandom});
         end
         LIM_NARROW: begin
            for (int c = 0; c < 2; c++) begin
               lo                   = $urandom_range(1015, 2);
               w[c * 20 +: 10]      = 10'(lo);
               w[c * 20 + 10 +: 10] = 10'(lo + $urandom_range(8) - 2);
            end
         end
         LIM_ALL_ONES: begin
            w = '1;
         end
         LIM_ALL_ZEROS: begin
            w = '0;
         end
         default: begin
            w = '0;
         end
      endcase
      return w;
   endfunction

   // Write one register; bits above its width carry random junk
   task automatic write_csr(input logic [REG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = {$urandom, $urandom};
      if (idx == REG_CONTRAST_LEVEL)
         word[CONTRAST_W-1:0] = value[CONTRAST_W-1:0];
      else
         word[CAL_W-1:0] = value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx < CAL_REGS)
         cal_limits[idx[CAL_IDX_W-1:0]] = word[CAL_W-1:0];
      else if (idx == REG_CONTRAST_LEVEL)
         contrast_level = word[CONTRAST_W-1:0];
      settings_written++;
   endtask

   // Hold until every scan is sent and every position word is back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_scans.size() != 0 || req_valid || predicted_positions.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_scans(input int count, input limit_style_type style,
                            input logic [CONTRAST_W-1:0] level);
      wait_idle();
      for (int k = 0; k < CAL_REGS; k++)
         write_csr(REG_IDX_W'(REG_CAL_PAIR_01 + k), limit_word(style));
      write_csr(REG_CONTRAST_LEVEL, CAL_W'(level));
      for (int i = 0; i < count; i++) pending_scans.push_back(random_scan());
   endtask

   // Drive scans from the pending queue, with short pauses and rare long gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_positions.push_back(estimate_position(req_data));
            scans_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_scans.size() != 0 && !take_pause()) begin
               req_valid <= 1'b1;
               req_data  <= pending_scans.pop_front();
               if (!quiet_window() && $urandom_range(99) < 6) gap_left = $urandom_range(220, 1);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each position word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_positions.size() == 0) begin
               $error("position word with no scan outstanding: position %0d",
                      $signed(rsp_data.position));
               failures++;
            end else begin
               want = predicted_positions.pop_front();
               results_checked++;
               if (rsp_data.position !== want.position) begin
                  $error("position: expected %0d, got %0d",
                         $signed(want.position), $signed(rsp_data.position));
                  failures++;
               end
               if (rsp_data.off_line !== want.off_line) begin
                  $error("off_line: expected %0d, got %0d", want.off_line, rsp_data.off_line);
                  failures++;
               end
               if (rsp_data.last_channel !== want.last_channel) begin
                  $error("last_channel: expected %0d, got %0d",
                         want.last_channel, rsp_data.last_channel);
                  failures++;
               end
               if (want.off_line) off_line_seen++;
               if ($signed(want.position) == POS_LIMIT || $signed(want.position) == -POS_LIMIT)
                  saturated_seen++;
            end
         end
         rsp_ready <= !take_pause();
      end
   end

   // Stimulus: directed corners, then random phases over several calibrations
   initial begin
      req_word_type scan;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default limits, contrast 0: empty sum, rails, peaks at both ends, ties
      pending_scans.push_back(make_scan(0, -1, 0));
      pending_scans.push_back(make_scan(1023, -1, 0));
      pending_scans.push_back(make_scan(0, CHANNELS - 1, 1023));
      pending_scans.push_back(make_scan(0, 0, 1023));
      pending_scans.push_back(make_scan(10'h2AA, -1, 0));
      pending_scans.push_back(make_scan(10'h155, -1, 0));
      scan = make_scan(0, 2, 1023);
      scan[(CHANNELS - 1 - 5) * SAMPLE_BITS +: SAMPLE_BITS] = 1023;
      pending_scans.push_back(scan);

      // full contrast: off-line scans after a last-channel and a middle peak
      wait_idle();
      write_csr(REG_CONTRAST_LEVEL, CAL_W'(1023));
      pending_scans.push_back(make_scan(0, CHANNELS - 1, 1023));
      pending_scans.push_back(make_scan(500, -1, 0));
      pending_scans.push_back(make_scan(0, 3, 1023));
      pending_scans.push_back(make_scan(200, -1, 0));
      pending_scans.push_back(make_scan(0, 4, 400));

      // degenerate, narrow and steep limits: negative values and saturation
      wait_idle();
      write_csr(REG_CAL_PAIR_01, {10'd500, 10'd500, 10'd0, 10'd1023});
      write_csr(REG_IDX_W'(REG_CAL_PAIR_01 + 1), {10'd1023, 10'd1000, 10'd1023, 10'd1000});
      write_csr(REG_IDX_W'(REG_CAL_PAIR_01 + 2), {10'd1, 10'd0, 10'd1, 10'd0});
      write_csr(REG_CAL_PAIR_67, {10'd1023, 10'd1022, 10'd1023, 10'd1022});
      write_csr(REG_CONTRAST_LEVEL, CAL_W'(0));
      pending_scans.push_back(make_scan(0, -1, 0));
      pending_scans.push_back(make_scan(1023, -1, 0));
      pending_scans.push_back(make_scan(0, CHANNELS - 1, 1023));
      pending_scans.push_back(make_scan(1023, 2, 0));
      pending_scans.push_back(make_scan(1010, 0, 0));

      run_scans(160, LIM_WIDE, 0);
      run_scans(160, LIM_WIDE, 1023);
      run_scans(150, LIM_RAW, $urandom_range(1023));
      run_scans(30, LIM_ALL_ONES, 0);
      run_scans(30, LIM_ALL_ZEROS, 1);
      run_scans(160, LIM_NARROW, $urandom_range(1023));
      run_scans(180, LIM_MIXED, $urandom_range(1023));
      run_scans(180, LIM_WIDE, 300);

      wait_idle();
      repeat (250) @(posedge clock);
      if (predicted_positions.size() != 0) begin
         $error("%0d position words never arrived", predicted_positions.size());
         failures++;
      end
      $display("Checked %0d position words across %0d register writes.",
               results_checked, settings_written);
      $display("Off-line scans: %0d, saturated positions: %0d, mismatches: %0d.",
               off_line_seen, saturated_seen, failures);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #30_000_000;
      $error("timed out with %0d position words outstanding", predicted_positions.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
design/lpe_pkg.sv
design/line_position_estimator_unit.sv
tb/tb_top.sv
